>>> hdl/vpcc_pkg.sv
package vpcc_pkg;

	localparam int unsigned MaxQueuesDefault = 8;
	localparam logic [15:0] NoVec = 16'hffff;
	localparam logic [7:0] StDriverOk = 8'h04;
	localparam logic [7:0] StFeaturesOk = 8'h08;
	localparam logic [7:0] StNeedsReset = 8'h40;
	localparam logic [7:0] StMask = 8'hcf;

	localparam logic [63:0] DevFeaturesReset = 64'd1104611901440;
	localparam logic [3:0] QueueCountReset = 4'd1;
	localparam logic [15:0] QueueSizeLimitReset = 16'd256;

	// configuration register indexes
	localparam logic [1:0] CfgDevFeatures = 2'd0;
	localparam logic [1:0] CfgQueueCount = 2'd1;
	localparam logic [1:0] CfgQueueSizeLimit = 2'd2;
	localparam logic [1:0] CfgMsiMode = 2'd3;

	// item modes
	localparam logic [1:0] ModeRead = 2'd0;
	localparam logic [1:0] ModeWrite = 2'd1;
	localparam logic [1:0] ModeQueueDone = 2'd2;
	localparam logic [1:0] ModeCfgChange = 2'd3;

	// window bases
	localparam logic [13:0] NotifyBase = 14'h1000;
	localparam logic [13:0] IsrBase = 14'h2000;
	localparam logic [13:0] DevCfgBase = 14'h3000;

	// common window offsets
	localparam logic [13:0] OffDevFeatSel = 14'h00;
	localparam logic [13:0] OffDevFeat = 14'h04;
	localparam logic [13:0] OffDrvFeatSel = 14'h08;
	localparam logic [13:0] OffDrvFeat = 14'h0c;
	localparam logic [13:0] OffCfgVector = 14'h10;
	localparam logic [13:0] OffNumQueues = 14'h12;
	localparam logic [13:0] OffStatus = 14'h14;
	localparam logic [13:0] OffGeneration = 14'h15;
	localparam logic [13:0] OffQueueSel = 14'h16;
	localparam logic [13:0] OffQueueSize = 14'h18;
	localparam logic [13:0] OffQueueVector = 14'h1a;
	localparam logic [13:0] OffQueueEnable = 14'h1c;
	localparam logic [13:0] OffNotifyOff = 14'h1e;
	localparam logic [13:0] OffDescLo = 14'h20;
	localparam logic [13:0] OffDescHi = 14'h24;
	localparam logic [13:0] OffDrvLo = 14'h28;
	localparam logic [13:0] OffDrvHi = 14'h2c;
	localparam logic [13:0] OffDevLo = 14'h30;
	localparam logic [13:0] OffDevHi = 14'h34;
	localparam logic [13:0] OffNotifyData = 14'h38;
	localparam logic [13:0] OffQueueReset = 14'h3a;

	typedef struct packed {
		logic [1:0]  mode;
		logic [13:0] offset;
		logic [63:0] write_data;
		logic [15:0] queue_id;
		logic        backend_ok;
	} item_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        resp_status;
		logic        irq_assert;
		logic        irq_deassert;
		logic [15:0] irq_vector;
		logic        notify_fire;
		logic [15:0] notify_queue;
	} result_t;

	typedef struct packed {
		logic [63:0] device_features;
		logic [3:0]  queue_count;
		logic [15:0] queue_size_limit;
		logic        msi_mode;
	} cfg_t;

endpackage

>>> hdl/virtio_pci_common_config_regs.sv
// channel  | direction | handshake              | payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata: offset, write_data, queue_id,
//          |           |                        |        backend_ok; tuser: mode
// m_axis   | out       | m_axis_tvalid/tready   | tdata: read_data, resp_status, irq_assert, irq_deassert,
//          |           |                        |        irq_vector, notify_fire, notify_queue
// cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
// One item per cycle: decode, state update and result are done in the cycle the item
// is taken; the result sits in the output register from the next cycle.
// The output register holds under back-pressure; a new item is taken whenever it is
// empty or being drained in the same cycle.
// Reset puts all state and queue entries at their reset values at once (not out_q); no clearing pass.
module virtio_pci_common_config_regs #(
	parameter int unsigned MAX_QUEUES = vpcc_pkg::MaxQueuesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // offset[13:0], write_data[77:14], queue_id[93:78],
	                                    // backend_ok[94]
	input  logic [1:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,  // read_data, resp_status, irq_assert, irq_deassert,
	                                    // irq_vector, notify_fire, notify_queue (bits 0..99)
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import vpcc_pkg::*;

	item_t   item;
	result_t res;
	cfg_t    cfg;
	logic    go;
	logic    out_valid_q;
	result_t out_q;

	assign item.offset = s_axis_tdata[13:0];
	assign item.write_data = s_axis_tdata[77:14];
	assign item.queue_id = s_axis_tdata[93:78];
	assign item.backend_ok = s_axis_tdata[94];
	assign item.mode = s_axis_tuser;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign go = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	vpcc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .wvalid(cfg_valid), .windex(cfg_index),
		.wdata(cfg_data), .cfg(cfg)
	);

	vpcc_core #(.MAX_QUEUES(MAX_QUEUES)) u_core (
		.clk(clk), .arst_n(arst_n), .go(go), .item(item), .cfg(cfg), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'd0, out_q.notify_queue, out_q.notify_fire, out_q.irq_vector,
		out_q.irq_deassert, out_q.irq_assert, out_q.resp_status, out_q.read_data};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item gave no result");
	a_irq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_q.irq_assert && out_q.irq_deassert))
		else $error("raise and lower in one result");
	a_notify: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !out_q.notify_fire |-> out_q.notify_queue == 16'd0)
		else $error("notify queue without fire");
endmodule

>>> hdl/vpcc_cfg.sv
module vpcc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wvalid,
	input  logic [1:0]         windex,
	input  logic [63:0]        wdata,
	output vpcc_pkg::cfg_t     cfg
);
	import vpcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_features <= DevFeaturesReset;
			cfg_q.queue_count <= QueueCountReset;
			cfg_q.queue_size_limit <= QueueSizeLimitReset;
			cfg_q.msi_mode <= 1'b0;
		end else if (wvalid) begin
			unique case (windex)
				CfgDevFeatures: cfg_q.device_features <= wdata;
				CfgQueueCount: cfg_q.queue_count <= wdata[3:0];
				CfgQueueSizeLimit: cfg_q.queue_size_limit <= wdata[15:0];
				CfgMsiMode: cfg_q.msi_mode <= wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> hdl/vpcc_core.sv
module vpcc_core #(
	parameter int unsigned MAX_QUEUES = vpcc_pkg::MaxQueuesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  vpcc_pkg::item_t     item,
	input  vpcc_pkg::cfg_t      cfg,
	output vpcc_pkg::result_t   res
);
	import vpcc_pkg::*;

	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

	logic [7:0]  dev_status_q;
	logic        dev_feat_sel_q;
	logic        drv_feat_sel_q;
	logic [63:0] drv_features_q;
	logic [15:0] config_vector_q;
	logic [7:0]  config_gen_q;
	logic [15:0] sel_queue_q;
	logic [1:0]  isr_bits_q;
	logic [31:0] last_notify_q;
	logic [15:0] q_size_q   [MAX_QUEUES];
	logic [15:0] q_vector_q [MAX_QUEUES];
	logic [63:0] q_desc_q   [MAX_QUEUES];
	logic [63:0] q_drv_q    [MAX_QUEUES];
	logic [63:0] q_dev_q    [MAX_QUEUES];
	logic [MAX_QUEUES-1:0] q_en_q;

	function automatic logic qvalid(input logic [15:0] q, input logic [3:0] cnt);
		qvalid = ({12'd0, cnt} > q) && (32'(q) < MAX_QUEUES);
	endfunction

	logic [QW-1:0] s_idx, n_idx, c_idx;
	logic s_v, n_v, c_v;
	logic [13:0] off;
	logic [63:0] d;
	logic [15:0] d16;
	logic [31:0] d32;
	logic ok, ready;
	result_t r;

	// next-state
	logic [7:0]  st_n;
	logic        dfs_n, drfs_n;
	logic [63:0] drf_n;
	logic [15:0] cv_n, sq_n;
	logic [7:0]  gen_n;
	logic [1:0]  isr_n;
	logic [31:0] ln_n;
	logic        clr_en;
	logic        wr_size, wr_vec, wr_en, en_val, qreset;
	logic [2:0]  wr_ring;
	logic        ring_hi;
	logic [15:0] size_val;
	logic [63:0] ring_sel;
	logic [7:0]  sv;

	assign off = item.offset;
	assign d = item.write_data;
	assign d16 = d[15:0];
	assign d32 = d[31:0];
	assign ok = item.backend_ok;
	assign s_idx = sel_queue_q[QW-1:0];
	assign n_idx = d16[QW-1:0];
	assign c_idx = item.queue_id[QW-1:0];
	assign s_v = qvalid(sel_queue_q, cfg.queue_count);
	assign n_v = qvalid(d16, cfg.queue_count);
	assign c_v = qvalid(item.queue_id, cfg.queue_count);
	assign ready = dev_status_q[2];
	assign size_val = (d16 > cfg.queue_size_limit) ? cfg.queue_size_limit : d16;
	assign sv = d[7:0] & StMask;

	always_comb begin
		r = '0;
		r.irq_vector = NoVec;
		st_n = dev_status_q; dfs_n = dev_feat_sel_q; drfs_n = drv_feat_sel_q;
		drf_n = drv_features_q; cv_n = config_vector_q; sq_n = sel_queue_q;
		gen_n = config_gen_q; isr_n = isr_bits_q; ln_n = last_notify_q;
		clr_en = 1'b0; wr_size = 1'b0; wr_vec = 1'b0; wr_en = 1'b0; en_val = 1'b0;
		qreset = 1'b0; wr_ring = 3'b000; ring_hi = off[2];
		ring_sel = 64'd0;
		unique case (off[5:3])
			3'd4: ring_sel = q_desc_q[s_idx];
			3'd5: ring_sel = q_drv_q[s_idx];
			3'd6: ring_sel = q_dev_q[s_idx];
			default: ring_sel = 64'd0;
		endcase
		unique case (item.mode)
			ModeRead: begin
				if (off < NotifyBase) begin
					unique case (off)
						OffDevFeatSel: r.read_data = {63'd0, dev_feat_sel_q};
						OffDevFeat: r.read_data = {32'd0, dev_feat_sel_q ?
							cfg.device_features[63:32] : cfg.device_features[31:0]};
						OffDrvFeatSel: r.read_data = {63'd0, drv_feat_sel_q};
						OffDrvFeat: r.read_data = {32'd0, drv_feat_sel_q ?
							drv_features_q[63:32] : drv_features_q[31:0]};
						OffCfgVector: r.read_data = {48'd0, config_vector_q};
						OffNumQueues: r.read_data = {60'd0, cfg.queue_count};
						OffStatus: r.read_data = {56'd0, dev_status_q};
						OffGeneration: r.read_data = {56'd0, config_gen_q};
						OffQueueSel: r.read_data = {48'd0, sel_queue_q};
						OffQueueSize: r.read_data = s_v ? {48'd0, q_size_q[s_idx]} : 64'd0;
						OffQueueVector: r.read_data = s_v ? {48'd0, q_vector_q[s_idx]} : 64'd0;
						OffQueueEnable: r.read_data = {63'd0, s_v & q_en_q[s_idx]};
						OffNotifyOff, OffNotifyData, OffQueueReset: r.read_data = 64'd0;
						OffDescLo, OffDescHi, OffDrvLo, OffDrvHi, OffDevLo, OffDevHi:
							r.read_data = !s_v ? 64'd0 :
								(ring_hi ? {32'd0, ring_sel[63:32]} : ring_sel);
						default: r.resp_status = 1'b1;
					endcase
				end else if (off < IsrBase) begin
					if (off == NotifyBase) r.read_data = {32'd0, last_notify_q};
					else r.resp_status = 1'b1;
				end else if (off < DevCfgBase) begin
					if (off == IsrBase) begin
						r.read_data = {62'd0, isr_bits_q};
						r.irq_deassert = |isr_bits_q;
						isr_n = 2'b00;
					end else r.resp_status = 1'b1;
				end else r.resp_status = !ok;
			end
			ModeWrite: begin
				if (off < NotifyBase) begin
					unique case (off)
						OffDevFeatSel: dfs_n = |d32;
						OffDrvFeatSel: drfs_n = |d32;
						OffDrvFeat: begin
							if (dev_status_q[3]) st_n = StNeedsReset;
							else if (drv_feat_sel_q) drf_n[63:32] = d32;
							else drf_n[31:0] = d32;
						end
						OffCfgVector: cv_n = d16;
						OffStatus: begin
							if (sv == 8'd0) begin
								clr_en = 1'b1; drf_n = 64'd0; st_n = 8'd0;
							end else begin
								st_n = sv;
								if (sv[3] && !sv[2] &&
									(((drv_features_q & ~cfg.device_features) != 64'd0) || !ok))
									st_n[3] = 1'b0;
							end
						end
						OffQueueSel: sq_n = d16;
						OffQueueSize: wr_size = s_v;
						OffQueueVector: wr_vec = s_v;
						OffQueueEnable: begin
							if (s_v) begin
								wr_en = 1'b1;
								en_val = d16 != 16'd0;
								if (en_val && !q_en_q[s_idx] && !ok) st_n = StNeedsReset;
							end
						end
						OffNotifyOff, OffNotifyData: ;
						OffQueueReset: qreset = (d16 == 16'd1) && s_v && q_en_q[s_idx];
						OffDescLo, OffDescHi, OffDrvLo, OffDrvHi, OffDevLo, OffDevHi: begin
							if (s_v) begin
								unique case (off[5:3])
									3'd4: wr_ring = 3'b001;
									3'd5: wr_ring = 3'b010;
									default: wr_ring = 3'b100;
								endcase
							end
						end
						default: r.resp_status = 1'b1;
					endcase
				end else if (off < IsrBase) begin
					if (off != NotifyBase) r.resp_status = 1'b1;
					else if (ready && n_v && q_en_q[n_idx]) begin
						ln_n = d32;
						r.notify_fire = 1'b1;
						r.notify_queue = d16;
						if (!ok) st_n = StNeedsReset;
					end
				end else if (off < DevCfgBase) begin
					r.resp_status = off != IsrBase;
				end else begin
					if (ok) gen_n = config_gen_q + 8'd1;
					else r.resp_status = 1'b1;
				end
			end
			ModeQueueDone: begin
				if (ready && c_v && q_en_q[c_idx] && ok &&
					(!cfg.msi_mode || q_vector_q[c_idx] != NoVec)) begin
					isr_n[0] = 1'b1;
					r.irq_assert = 1'b1;
					r.irq_vector = q_vector_q[c_idx];
				end
			end
			ModeCfgChange: begin
				if (ready) begin
					isr_n[1] = 1'b1;
					r.irq_assert = 1'b1;
					r.irq_vector = config_vector_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_status_q <= '0; dev_feat_sel_q <= 1'b0; drv_feat_sel_q <= 1'b0;
			drv_features_q <= '0; config_vector_q <= NoVec; config_gen_q <= '0;
			sel_queue_q <= '0; isr_bits_q <= '0; last_notify_q <= '0; q_en_q <= '0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				q_size_q[i] <= '0; q_vector_q[i] <= NoVec;
				q_desc_q[i] <= '0; q_drv_q[i] <= '0; q_dev_q[i] <= '0;
			end
		end else if (go) begin
			dev_status_q <= st_n; dev_feat_sel_q <= dfs_n; drv_feat_sel_q <= drfs_n;
			drv_features_q <= drf_n; config_vector_q <= cv_n; config_gen_q <= gen_n;
			sel_queue_q <= sq_n; isr_bits_q <= isr_n; last_notify_q <= ln_n;
			if (clr_en) q_en_q <= '0;
			if (wr_en) q_en_q[s_idx] <= en_val;
			if (wr_size) q_size_q[s_idx] <= size_val;
			if (wr_vec) q_vector_q[s_idx] <= d16;
			if (wr_ring[0]) q_desc_q[s_idx] <= ring_hi ? {d32, q_desc_q[s_idx][31:0]} : d;
			if (wr_ring[1]) q_drv_q[s_idx] <= ring_hi ? {d32, q_drv_q[s_idx][31:0]} : d;
			if (wr_ring[2]) q_dev_q[s_idx] <= ring_hi ? {d32, q_dev_q[s_idx][31:0]} : d;
			if (qreset) begin
				q_en_q[s_idx] <= 1'b0; q_size_q[s_idx] <= '0; q_vector_q[s_idx] <= NoVec;
				q_desc_q[s_idx] <= '0; q_drv_q[s_idx] <= '0; q_dev_q[s_idx] <= '0;
			end
		end
	end

	assign res = r;
endmodule

>>> sim/virtio_pci_common_config_regs_test.sv
`timescale 1ns / 1ps

module virtio_pci_common_config_regs_test;
	import vpcc_pkg::*;

	typedef struct {
		logic [1:0]  mode;
		logic [13:0] offset;
		logic [63:0] wdata;
		logic [15:0] qid;
		logic        ok;
		bit          known;
		logic [63:0] rd;
		logic        rs;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;  // offset, write_data, queue_id, backend_ok
	logic [1:0]   s_axis_tuser = '0;  // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;       // read_data, resp_status, irq_assert, irq_deassert,
	                                  // irq_vector, notify_fire, notify_queue
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	virtio_pci_common_config_regs uut (.*);

	always #5 clk = ~clk;

	// shadow of the device registers
	logic [63:0] sh_dev_feat;
	logic [3:0]  sh_qcount;
	logic [15:0] sh_limit;
	logic        sh_msi;
	logic [7:0]  sh_status;
	logic        sh_dfs, sh_drfs;
	logic [63:0] sh_drv_feat;
	logic [15:0] sh_cfg_vec;
	logic [7:0]  sh_gen;
	logic [15:0] sh_qsel;
	logic [1:0]  sh_isr;
	logic [31:0] sh_last_notify;
	logic [15:0] sh_qsize [8];
	logic [15:0] sh_qvec [8];
	logic [63:0] sh_ring [24];
	logic        sh_qen [8];

	result_t pending_results [$];
	row_t    dir_rows [$];
	row_t    cur;
	int      mismatches = 0;
	int      idle_mode = 0;
	bit      hold_req = 1'b0;

	function automatic bit q_ok(logic [15:0] q);
		return q < sh_qcount && q < 8;
	endfunction

	function automatic result_t predict_access(row_t it);
		result_t r;
		logic [15:0] s, d16;
		logic [63:0] d32;
		logic [7:0]  v;
		bit          vq;
		int          idx;
		r = '0;
		r.irq_vector = NoVec;
		s = sh_qsel;
		vq = q_ok(s);
		d16 = it.wdata[15:0];
		d32 = {32'd0, it.wdata[31:0]};
		idx = 0;
		if (it.offset >= OffDescLo && it.offset <= OffDevHi)
			idx = s * 3 + ((it.offset - OffDescLo) >> 3);
		case (it.mode)
		ModeRead: begin
			if (it.offset < NotifyBase) begin
				case (it.offset)
				OffDevFeatSel: r.read_data = 64'(sh_dfs);
				OffDevFeat: r.read_data = 64'(sh_dfs ? sh_dev_feat[63:32] : sh_dev_feat[31:0]);
				OffDrvFeatSel: r.read_data = 64'(sh_drfs);
				OffDrvFeat: r.read_data = 64'(sh_drfs ? sh_drv_feat[63:32] : sh_drv_feat[31:0]);
				OffCfgVector: r.read_data = 64'(sh_cfg_vec);
				OffNumQueues: r.read_data = 64'(sh_qcount);
				OffStatus: r.read_data = 64'(sh_status);
				OffGeneration: r.read_data = 64'(sh_gen);
				OffQueueSel: r.read_data = 64'(s);
				OffQueueSize: r.read_data = vq ? 64'(sh_qsize[s[2:0]]) : 64'd0;
				OffQueueVector: r.read_data = vq ? 64'(sh_qvec[s[2:0]]) : 64'd0;
				OffQueueEnable: r.read_data = (vq && sh_qen[s[2:0]]) ? 1 : 0;
				OffNotifyOff, OffNotifyData, OffQueueReset: r.read_data = 0;
				OffDescLo, OffDrvLo, OffDevLo:
					r.read_data = vq ? sh_ring[idx] : 0;
				OffDescHi, OffDrvHi, OffDevHi:
					r.read_data = vq ? sh_ring[idx] >> 32 : 0;
				default: r.resp_status = 1'b1;
				endcase
			end else if (it.offset < IsrBase) begin
				if (it.offset == NotifyBase) r.read_data = 64'(sh_last_notify);
				else r.resp_status = 1'b1;
			end else if (it.offset < DevCfgBase) begin
				if (it.offset == IsrBase) begin
					r.read_data = 64'(sh_isr);
					r.irq_deassert = sh_isr != 0;
					sh_isr = 0;
				end else begin
					r.resp_status = 1'b1;
				end
			end else begin
				r.resp_status = !it.ok;
			end
		end
		ModeWrite: begin
			if (it.offset < NotifyBase) begin
				case (it.offset)
				OffDevFeatSel: sh_dfs = d32 != 0;
				OffDrvFeatSel: sh_drfs = d32 != 0;
				OffDrvFeat: begin
					if (sh_status & StFeaturesOk) sh_status = StNeedsReset;
					else if (sh_drfs) sh_drv_feat[63:32] = d32[31:0];
					else sh_drv_feat[31:0] = d32[31:0];
				end
				OffCfgVector: sh_cfg_vec = d16;
				OffStatus: begin
					v = it.wdata[7:0] & StMask;
					if (v == 0) begin
						foreach (sh_qen[q]) sh_qen[q] = 1'b0;
						sh_drv_feat = 0;
						sh_status = 0;
					end else begin
						sh_status = v;
						if ((v & StFeaturesOk) && !(v & StDriverOk) &&
						    ((sh_drv_feat & ~sh_dev_feat) != 0 || !it.ok))
							sh_status = sh_status & ~StFeaturesOk;
					end
				end
				OffQueueSel: sh_qsel = d16;
				OffQueueSize: if (vq) sh_qsize[s[2:0]] = d16 > sh_limit ? sh_limit : d16;
				OffQueueVector: if (vq) sh_qvec[s[2:0]] = d16;
				OffQueueEnable: begin
					if (vq) begin
						if (d16 != 0) begin
							if (!sh_qen[s[2:0]]) begin
								sh_qen[s[2:0]] = 1'b1;
								if (!it.ok) sh_status = StNeedsReset;
							end
						end else begin
							sh_qen[s[2:0]] = 1'b0;
						end
					end
				end
				OffNotifyOff, OffNotifyData: ;
				OffQueueReset: begin
					if (d16 == 1 && vq && sh_qen[s[2:0]]) begin
						sh_qen[s[2:0]] = 1'b0;
						sh_qsize[s[2:0]] = 0;
						sh_qvec[s[2:0]] = NoVec;
						sh_ring[s * 3] = 0;
						sh_ring[s * 3 + 1] = 0;
						sh_ring[s * 3 + 2] = 0;
					end
				end
				OffDescLo, OffDrvLo, OffDevLo: if (vq) sh_ring[idx] = it.wdata;
				OffDescHi, OffDrvHi, OffDevHi: if (vq) sh_ring[idx][63:32] = d32[31:0];
				default: r.resp_status = 1'b1;
				endcase
			end else if (it.offset < IsrBase) begin
				if (it.offset != NotifyBase) begin
					r.resp_status = 1'b1;
				end else if ((sh_status & StDriverOk) && q_ok(d16) && sh_qen[d16[2:0]]) begin
					sh_last_notify = it.wdata[31:0];
					r.notify_fire = 1'b1;
					r.notify_queue = d16;
					if (!it.ok) sh_status = StNeedsReset;
				end
			end else if (it.offset < DevCfgBase) begin
				r.resp_status = it.offset != IsrBase;
			end else begin
				if (it.ok) sh_gen = sh_gen + 8'd1;
				else r.resp_status = 1'b1;
			end
		end
		ModeQueueDone: begin
			if ((sh_status & StDriverOk) && q_ok(it.qid) && sh_qen[it.qid[2:0]] && it.ok &&
			    (!sh_msi || sh_qvec[it.qid[2:0]] != NoVec)) begin
				sh_isr[0] = 1'b1;
				r.irq_assert = 1'b1;
				r.irq_vector = sh_qvec[it.qid[2:0]];
			end
		end
		default: begin
			if (sh_status & StDriverOk) begin
				sh_isr[1] = 1'b1;
				r.irq_assert = 1'b1;
				r.irq_vector = sh_cfg_vec;
			end
		end
		endcase
		return r;
	endfunction

	initial begin
		sh_dev_feat = DevFeaturesReset;
		sh_qcount = QueueCountReset;
		sh_limit = QueueSizeLimitReset;
		sh_msi = 1'b0;
		sh_status = 0;
		sh_dfs = 0;
		sh_drfs = 0;
		sh_drv_feat = 0;
		sh_cfg_vec = NoVec;
		sh_gen = 0;
		sh_qsel = 0;
		sh_isr = 0;
		sh_last_notify = 0;
		for (int q = 0; q < 8; q++) begin
			sh_qsize[q] = 0;
			sh_qvec[q] = NoVec;
			sh_qen[q] = 1'b0;
		end
		foreach (sh_ring[i]) sh_ring[i] = 0;
	end

	// predict on the item taken at the next edge; values are settled at the falling edge
	always @(negedge clk) begin
		row_t    it;
		result_t got, want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
			CfgDevFeatures: sh_dev_feat = cfg_data;
			CfgQueueCount: sh_qcount = cfg_data[3:0];
			CfgQueueSizeLimit: sh_limit = cfg_data[15:0];
			default: sh_msi = cfg_data[0];
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			it = cur;
			it.mode = s_axis_tuser;
			it.offset = s_axis_tdata[13:0];
			it.wdata = s_axis_tdata[77:14];
			it.qid = s_axis_tdata[93:78];
			it.ok = s_axis_tdata[94];
			want = predict_access(it);
			if (it.known) begin
				want.read_data = it.rd;
				want.resp_status = it.rs;
			end
			pending_results.insert(pending_results.size(), want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.read_data = m_axis_tdata[63:0];
			got.resp_status = m_axis_tdata[64];
			got.irq_assert = m_axis_tdata[65];
			got.irq_deassert = m_axis_tdata[66];
			got.irq_vector = m_axis_tdata[82:67];
			got.notify_fire = m_axis_tdata[83];
			got.notify_queue = m_axis_tdata[99:84];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.read_data !== want.read_data || got.resp_status !== want.resp_status ||
				    got.irq_assert !== want.irq_assert ||
				    got.irq_deassert !== want.irq_deassert ||
				    got.irq_vector !== want.irq_vector ||
				    got.notify_fire !== want.notify_fire ||
				    got.notify_queue !== want.notify_queue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	// receiver: random stalls in idle modes 2 and 3, plus one long hold-off on request
	always @(posedge clk) begin
		int hold;
		if (hold_req && hold == 0) hold = 300;
		if (hold > 0) begin
			hold = hold - 1;
			if (hold == 0) hold_req <= 1'b0;
			m_axis_tready <= 1'b0;
		end else if (idle_mode == 2) begin
			m_axis_tready <= $urandom_range(99) >= 55;
		end else if (idle_mode == 3) begin
			m_axis_tready <= $urandom_range(99) >= 12;
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	task automatic send_access(row_t it);
		while ((idle_mode == 1 && $urandom_range(99) < 55) ||
		       (idle_mode == 3 && $urandom_range(99) < 12)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		cur = it;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {1'b0, it.ok, it.qid, it.wdata, it.offset};
		s_axis_tvalid <= 1'b1;
		do @(negedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(posedge clk);
	endtask

	task automatic put(logic [1:0] m, logic [13:0] o, logic [63:0] d, logic [15:0] q,
	                   logic ok, bit k = 0, logic [63:0] rd = 0, logic rs = 0);
		row_t r;
		r.mode = m; r.offset = o; r.wdata = d; r.qid = q; r.ok = ok;
		r.known = k; r.rd = rd; r.rs = rs;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!(cfg_valid && cfg_ready));
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [13:0] pick_offset();
		logic [13:0] common [21] = '{OffDevFeatSel, OffDevFeat, OffDrvFeatSel, OffDrvFeat,
			OffCfgVector, OffNumQueues, OffStatus, OffGeneration, OffQueueSel, OffQueueSize,
			OffQueueVector, OffQueueEnable, OffNotifyOff, OffDescLo, OffDescHi, OffDrvLo,
			OffDrvHi, OffDevLo, OffDevHi, OffNotifyData, OffQueueReset};
		int p;
		p = $urandom_range(99);
		if (p < 60) return common[$urandom_range(20)];
		if (p < 72) return NotifyBase;
		if (p < 82) return IsrBase;
		if (p < 90) return DevCfgBase + 14'($urandom_range(4095));
		return 14'($urandom);
	endfunction

	function automatic row_t rand_access();
		row_t r;
		int p;
		r.known = 0; r.rd = 0; r.rs = 0;
		p = $urandom_range(99);
		r.mode = p < 35 ? ModeRead : p < 80 ? ModeWrite : p < 92 ? ModeQueueDone : ModeCfgChange;
		r.offset = pick_offset();
		r.wdata = $urandom_range(3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(15));
		if (r.offset == OffStatus && $urandom_range(1)) r.wdata[7:0] = 8'h0f;
		r.qid = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(9));
		r.ok = $urandom_range(9) != 0;
		return r;
	endfunction

	task automatic bring_up();
		logic [15:0] q;
		row_t r;
		q = 16'($urandom_range(8));
		r = rand_access();
		r.mode = ModeWrite; r.ok = 1'b1;
		r.offset = OffStatus; r.wdata = 64'h0b; send_access(r);
		r.offset = OffQueueSel; r.wdata = {$urandom, $urandom}; r.wdata[15:0] = q;
		send_access(r);
		r.offset = OffQueueSize; r.wdata = 64'($urandom); send_access(r);
		r.offset = OffQueueVector; r.wdata = 64'($urandom_range(3)); send_access(r);
		r.offset = OffQueueEnable; r.wdata = 64'd1; r.ok = $urandom_range(7) != 0;
		send_access(r);
		r.offset = OffStatus; r.wdata = 64'h0f; r.ok = 1'b1; send_access(r);
		r.offset = NotifyBase; r.wdata = {$urandom, $urandom}; r.wdata[15:0] = q;
		send_access(r);
		r.mode = ModeQueueDone; r.qid = q; send_access(r);
	endtask

	initial begin
		logic [63:0] feats [5];
		logic [3:0]  counts [5] = '{4'd1, 4'd0, 4'd8, 4'd3, 4'd8};
		logic [15:0] limits [5];
		logic        msis [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		row_t        r;
		feats = '{DevFeaturesReset, '1, 64'd0, {$urandom, $urandom}, {$urandom, $urandom}};
		limits = '{QueueSizeLimitReset, 16'd0, 16'hffff, 16'($urandom), 16'd16};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 5; ph++) begin
			idle_mode = ph % 4;
			write_cfg(CfgDevFeatures, feats[ph]);
			write_cfg(CfgQueueCount, 64'(counts[ph]));
			write_cfg(CfgQueueSizeLimit, 64'(limits[ph]));
			write_cfg(CfgMsiMode, 64'(msis[ph]));
			if (ph == 0) begin
				put(ModeRead, OffDevFeatSel, 0, 0, 1, 1, 0, 0);
				put(ModeRead, OffDevFeat, 0, 0, 1, 1, 64'(DevFeaturesReset[31:0]), 0);
				put(ModeRead, OffCfgVector, 0, 0, 1, 1, 64'(NoVec), 0);
				put(ModeRead, OffNumQueues, 0, 0, 1, 1, 64'(QueueCountReset), 0);
				put(ModeRead, OffStatus, 0, 0, 1, 1, 0, 0);
				put(ModeRead, OffQueueVector, 0, 0, 1, 1, 64'(NoVec), 0);
				put(ModeRead, NotifyBase, 0, 0, 1, 1, 0, 0);
				put(ModeRead, IsrBase, 0, 0, 1, 1, 0, 0);
				put(ModeRead, 14'h06, 0, 0, 1, 1, 0, 1);
				put(ModeWrite, OffDevFeat, '1, 0, 1, 1, 0, 1);
				put(ModeWrite, OffNumQueues, '1, 0, 1, 1, 0, 1);
				put(ModeRead, NotifyBase + 14'd2, 0, 0, 1, 1, 0, 1);
				put(ModeWrite, IsrBase + 14'd4, '1, 0, 1, 1, 0, 1);
				put(ModeRead, DevCfgBase, 0, 0, 0, 1, 0, 1);
				put(ModeWrite, DevCfgBase, '1, '1, 1, 1, 0, 0);
				put(ModeWrite, OffDevFeatSel, 1, 0, 1);
				put(ModeRead, OffDevFeat, 0, 0, 1, 1, 64'(DevFeaturesReset[63:32]), 0);
				put(ModeWrite, OffQueueSize, 64'hffff, 0, 1);
				put(ModeRead, OffQueueSize, 0, 0, 1, 1, 64'(QueueSizeLimitReset), 0);
				put(ModeWrite, OffStatus, 64'h0b, 0, 1);
				put(ModeWrite, OffQueueEnable, 1, 0, 1);
				put(ModeWrite, OffStatus, 64'hff, 0, 1);
				put(ModeWrite, NotifyBase, 0, 0, 1);
				put(ModeQueueDone, 0, 0, 0, 1);
				put(ModeCfgChange, 0, 0, 0, 1);
				put(ModeRead, IsrBase, 0, 0, 1, 1, 3, 0);
				put(ModeWrite, OffQueueReset, 1, 0, 1);
				put(ModeWrite, OffStatus, 0, 0, 1);
				put(ModeRead, 14'h3fff, 0, 0, 1, 1, 0, 0);
				while (dir_rows.size() != 0) send_access(dir_rows.pop_front());
			end
			if (ph == 1) hold_req = 1'b1;
			for (int n = 0; n < 200; ) begin
				if ($urandom_range(9) == 0) begin
					bring_up();
					n += 8;
				end else begin
					r = rand_access();
					send_access(r);
					n++;
				end
			end
			drain();
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
